// ===== rtl/core/chkv_pkg.sv =====
// Package with the shared types and constants of the chained hash key-value table.
package chkv_pkg;

  localparam int CFG_W     = 11;
  localparam int KEY_W     = 32;
  localparam int DEF_SLOTS = 1024;
  localparam int TS_RESET  = 1024;

  typedef enum logic [1:0] {
    ACT_FIND = 2'd0,
    ACT_GET  = 2'd1,
    ACT_PUT  = 2'd2,
    ACT_DEL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  data;
    logic [CFG_W-1:0]  stored_count;
  } out_word_t;

  typedef struct packed {
    in_word_t          item;
    logic [CFG_W-1:0]  bucket;
  } fb_word_t;

  typedef struct packed {
    logic              clearing;
    logic [CFG_W-1:0]  table_size;
  } bk_status_t;

endpackage

// ===== rtl/core/chkv_front.sv =====
// Front end: accepts words, reduces key modulo table size, queues them for the back end.
module chkv_front import chkv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_word_t   in_word,
  input  bk_status_t bs,
  input  logic       q_pop,
  output logic       q_empty,
  output fb_word_t   q_word
);

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [KEY_W-1:0] dv_r, dv_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  in_word_t         item_r, item_nxt;
  logic [CFG_W:0]   trial;

  fb_word_t         q_mem_r [2];
  logic             q_wp_r, q_rp_r;
  logic [1:0]       q_cnt_r;
  logic             q_push;

  assign in_full = busy_r | bs.clearing;
  assign q_empty = (q_cnt_r == 2'd0);
  assign q_word  = q_mem_r[q_rp_r];
  assign trial   = {rem_r, dv_r[KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    item_nxt = item_r;
    q_push   = 1'b0;
    // one restoring step per cycle
    if (busy_r && !pend_r) begin
      if (trial >= {1'b0, bs.table_size}) begin
        rem_nxt = CFG_W'(trial - {1'b0, bs.table_size});
      end else begin
        rem_nxt = trial[CFG_W-1:0];
      end
      dv_nxt  = {dv_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        pend_nxt = 1'b1;
      end
    end
    if (pend_r && q_cnt_r != 2'd2) begin
      q_push   = 1'b1;
      busy_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
    if (in_push && !in_full) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      cnt_nxt  = 5'd0;
      rem_nxt  = '0;
      dv_nxt   = in_word.key;
      item_nxt = in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      if (q_push) begin
        q_wp_r <= ~q_wp_r;
      end
      if (q_pop && !q_empty) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, q_push} - {1'b0, (q_pop && !q_empty)};
    end
  end

  always_ff @(posedge clk) begin
    dv_r   <= dv_nxt;
    rem_r  <= rem_nxt;
    item_r <= item_nxt;
    if (q_push) begin
      q_mem_r[q_wp_r] <= '{item: item_r, bucket: rem_r};
    end
  end

endmodule

// ===== rtl/core/chkv_back.sv =====
// Back end: chain walk, insert and delete over the slot memories, clearing pass, result queue.
module chkv_back import chkv_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             q_empty,
  input  fb_word_t         q_word,
  output logic             q_pop,
  output bk_status_t       bs,
  output logic             out_empty,
  input  logic             out_pop,
  output out_word_t        out_word
);

  localparam int SW      = $clog2(SLOTS + 1);
  localparam int BW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMPW    = (SW > CFG_W) ? SW : CFG_W;
  localparam int TS_INIT = (TS_RESET > SLOTS) ? SLOTS : TS_RESET;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_HEAD   = 13'b0000000000100,
    S_LINK   = 13'b0000000001000,
    S_WALK   = 13'b0000000010000,
    S_CMP    = 13'b0000000100000,
    S_ALLOC  = 13'b0000001000000,
    S_ALLOCW = 13'b0000010000000,
    S_APPEND = 13'b0000100000000,
    S_DEL1   = 13'b0001000000000,
    S_DEL2   = 13'b0010000000000,
    S_PUTW   = 13'b0100000000000,
    S_RESP   = 13'b1000000000000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [CFG_W-1:0] ts_r, ts_nxt;
  logic [SW-1:0]    clr_r, clr_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [SW-1:0]    prev_r, prev_nxt;
  logic [CFG_W-1:0] steps_r, steps_nxt;
  logic [SW-1:0]    free_r, free_nxt;
  logic [CFG_W-1:0] kcnt_r, kcnt_nxt;
  fb_word_t         item_r, item_nxt;
  logic [SW-1:0]    nhit_r, nhit_nxt;
  out_word_t        res_r, res_nxt;
  logic [CFG_W-1:0] lim;

  // memories
  logic [SW-1:0]    bh_mem [SLOTS];
  logic [SW-1:0]    sn_mem [SLOTS+1];
  logic [KEY_W-1:0] sk_mem [SLOTS+1];
  logic [KEY_W-1:0] sv_mem [SLOTS+1];
  logic             bh_we, sn_we, sk_we, sv_we;
  logic [BW-1:0]    bh_waddr;
  logic [SW-1:0]    bh_wdata, sn_waddr, sn_wdata, sl_waddr;
  logic [KEY_W-1:0] sk_wdata, sv_wdata;
  logic [SW-1:0]    bh_rdata, sn_rdata;
  logic [KEY_W-1:0] sk_rdata, sv_rdata;
  logic [BW-1:0]    bucket;

  out_word_t        o_mem_r [2];
  logic             o_wp_r, o_rp_r;
  logic [1:0]       o_cnt_r;
  logic             o_push;

  assign cfg_ready     = 1'b1;
  assign bs.clearing   = (state_r == S_CLEAR);
  assign bs.table_size = ts_r;
  assign bucket        = BW'(item_r.bucket);
  assign out_empty     = (o_cnt_r == 2'd0);
  assign out_word      = o_mem_r[o_rp_r];

  always_comb begin
    lim = cfg_data;
    if (lim == '0) begin
      lim = CFG_W'(1);
    end
    if (32'(lim) > 32'(SLOTS)) begin
      lim = CFG_W'(SLOTS);
    end
  end

  always_comb begin
    state_nxt = state_r;
    ts_nxt    = ts_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    steps_nxt = steps_r;
    free_nxt  = free_r;
    kcnt_nxt  = kcnt_r;
    item_nxt  = item_r;
    nhit_nxt  = nhit_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    o_push    = 1'b0;
    bh_we     = 1'b0;
    bh_waddr  = bucket;
    bh_wdata  = '0;
    sn_we     = 1'b0;
    sn_waddr  = cur_r;
    sn_wdata  = '0;
    sk_we     = 1'b0;
    sv_we     = 1'b0;
    sl_waddr  = cur_r;
    sk_wdata  = item_r.item.key;
    sv_wdata  = item_r.item.value;

    unique case (state_r)
      S_CLEAR: begin
        // empty one bucket and rebuild one free link per cycle
        if (32'(clr_r) < 32'(SLOTS)) begin
          bh_we    = 1'b1;
          bh_waddr = BW'(clr_r);
        end
        sn_we    = 1'b1;
        sn_waddr = clr_r;
        if (clr_r != '0 && CMPW'(clr_r) < CMPW'(ts_r)) begin
          sn_wdata = SW'(clr_r + 1'b1);
        end
        clr_nxt = SW'(clr_r + 1'b1);
        if (32'(clr_r) == 32'(SLOTS)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          item_nxt  = q_word;
          prev_nxt  = '0;
          steps_nxt = '0;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        cur_nxt   = bh_rdata;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (cur_r == '0 || CMPW'(cur_r) > CMPW'(ts_r) || steps_r >= ts_r) begin
          res_nxt.data = '0;
          if (item_r.item.action == ACT_FIND || item_r.item.action == ACT_DEL) begin
            res_nxt.status = ST_MISSING;
            state_nxt      = S_RESP;
          end else if (free_r == '0 || CMPW'(free_r) > CMPW'(ts_r)) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            cur_nxt   = free_r;
            state_nxt = S_ALLOC;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sk_rdata == item_r.item.key) begin
          res_nxt.status = ST_FOUND;
          res_nxt.data   = sv_rdata;
          nhit_nxt       = sn_rdata;
          case (item_r.item.action)
            ACT_DEL: state_nxt = S_DEL1;
            ACT_PUT: begin
              res_nxt.data = item_r.item.value;
              state_nxt    = S_PUTW;
            end
            default: state_nxt = S_RESP;
          endcase
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = sn_rdata;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_ALLOC: begin
        state_nxt = S_ALLOCW;
      end
      S_ALLOCW: begin
        // pop the free list and fill the new slot
        free_nxt = sn_rdata;
        sn_we    = 1'b1;
        sk_we    = 1'b1;
        sv_we    = 1'b1;
        if (item_r.item.action != ACT_PUT) begin
          sv_wdata = '0;
        end
        state_nxt = S_APPEND;
      end
      S_APPEND: begin
        if (prev_r == '0) begin
          bh_we    = 1'b1;
          bh_wdata = cur_r;
        end else begin
          sn_we    = 1'b1;
          sn_waddr = prev_r;
          sn_wdata = cur_r;
        end
        kcnt_nxt       = kcnt_r + 1'b1;
        res_nxt.status = ST_INSERTED;
        res_nxt.data   = (item_r.item.action == ACT_PUT) ? item_r.item.value : '0;
        state_nxt      = S_RESP;
      end
      S_DEL1: begin
        if (prev_r == '0) begin
          bh_we    = 1'b1;
          bh_wdata = nhit_r;
        end else begin
          sn_we    = 1'b1;
          sn_waddr = prev_r;
          sn_wdata = nhit_r;
        end
        state_nxt = S_DEL2;
      end
      S_DEL2: begin
        // push the slot back on the free list
        sn_we    = 1'b1;
        sn_wdata = free_r;
        free_nxt = cur_r;
        if (kcnt_r != '0) begin
          kcnt_nxt = kcnt_r - 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_PUTW: begin
        sv_we     = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (o_cnt_r != 2'd2) begin
          o_push    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    if (cfg_valid) begin
      ts_nxt    = lim;
      clr_nxt   = '0;
      free_nxt  = SW'(1);
      kcnt_nxt  = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ts_r    <= CFG_W'(TS_INIT);
      clr_r   <= '0;
      free_r  <= SW'(1);
      kcnt_r  <= '0;
      o_wp_r  <= 1'b0;
      o_rp_r  <= 1'b0;
      o_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      ts_r    <= ts_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
      kcnt_r  <= kcnt_nxt;
      if (o_push) begin
        o_wp_r <= ~o_wp_r;
      end
      if (out_pop && !out_empty) begin
        o_rp_r <= ~o_rp_r;
      end
      o_cnt_r <= o_cnt_r + {1'b0, o_push} - {1'b0, (out_pop && !out_empty)};
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    item_r  <= item_nxt;
    nhit_r  <= nhit_nxt;
    res_r   <= res_nxt;
    if (o_push) begin
      o_mem_r[o_wp_r] <= '{status: res_r.status, data: res_r.data, stored_count: kcnt_r};
    end
  end

  always_ff @(posedge clk) begin
    if (bh_we) begin
      bh_mem[bh_waddr] <= bh_wdata;
    end
    bh_rdata <= bh_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (sn_we) begin
      sn_mem[sn_waddr] <= sn_wdata;
    end
    sn_rdata <= sn_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      sk_mem[sl_waddr] <= sk_wdata;
    end
    sk_rdata <= sk_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (sv_we) begin
      sv_mem[sl_waddr] <= sv_wdata;
    end
    sv_rdata <= sv_mem[cur_r];
  end

endmodule

// ===== rtl/core/chained_hash_key_value_table.sv =====
// Top level of the chained hash key-value table: front end, queue and back end.
// Flow: the modulo front end reduces the key one bit per step, then the back end reads the
//   bucket head, compares each chain slot in turn, and does any put, delete or insert
//   writes before the word shows on out_word.
// A new word is taken once the last one is queued; the back end serves one word at a time.
// Reset (rst_n low, synchronous) and any table_size write start a clearing pass over bucket
//   heads and free links; in_full stays high while it runs.
module chained_hash_key_value_table import chkv_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_word_t         in_word,
  output logic             out_empty,
  input  logic             out_pop,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // front to back queue handshake and back-end status
  bk_status_t bs;
  fb_word_t   q_word;
  logic       q_empty;
  logic       q_pop;

  // accept and reduce the key to its bucket
  chkv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .bs      (bs),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_word  (q_word)
  );

  // walk the chain, update the table, queue the result word
  chkv_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .bs        (bs),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
